// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property sampled on i_clk, disabled while reset is held.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Asserts that a condition never holds at a sampled clock edge.
`define ASSERT_NEVER(lbl, cond) \
    `ASSERT_CLK(lbl, !(cond))

`endif

// ===== src/stafm_pkg.sv =====
// Package for the suffix sorter: word type, chain size, control structs and states.
// Used by every module of the block; depends on nothing.
package stafm_pkg;

    localparam int CAPACITY = 64;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic insert;
        logic unload;
    } t_cell_ctl;

    typedef struct packed {
        logic second_valid;
        logic full;
    } t_chain_stat;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_EMIT,
        ST_EMPTY
    } t_state;

endpackage

// ===== src/stafm_cell.sv =====
// One cell of the insertion chain: holds one word and its valid bit.
// Depends on stafm_pkg for the word type and the control struct.
module stafm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stafm_pkg::t_cell_ctl  i_ctl,
    input  stafm_pkg::t_word      i_x,
    input  logic                  i_left_take,
    input  stafm_pkg::t_word      i_left_value,
    input  logic                  i_left_valid,
    input  stafm_pkg::t_word      i_right_value,
    input  logic                  i_right_valid,
    output logic                  o_take,
    output stafm_pkg::t_word      o_value,
    output logic                  o_valid
);
    import stafm_pkg::*;

    t_word r_value;
    t_word n_value;
    logic  r_valid;
    logic  n_valid;

    // A cell takes part in an insertion when it is empty or holds a larger word.
    assign o_take = !r_valid || (r_value > i_x);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.unload) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.insert) begin
            if (i_left_take) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else if (o_take) begin
                n_value = i_x;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== src/stafm_chain.sv =====
// Row of insertion cells that keeps the stored words in ascending order.
// Depends on stafm_pkg and stafm_cell.
module stafm_chain (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stafm_pkg::t_cell_ctl   i_ctl,
    input  stafm_pkg::t_word       i_x,
    output stafm_pkg::t_word       o_head_value,
    output stafm_pkg::t_chain_stat o_stat
);
    import stafm_pkg::*;

    t_word value [CAPACITY];
    logic  valid [CAPACITY];
    logic  take  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic  left_take;
        t_word left_value;
        logic  left_valid;
        t_word right_value;
        logic  right_valid;

        if (g == 0) begin : g_first
            assign left_take  = 1'b0;
            assign left_value = '0;
            assign left_valid = 1'b0;
        end else begin : g_inner_left
            assign left_take  = take[g-1];
            assign left_value = value[g-1];
            assign left_valid = valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_right
            assign right_value = value[g+1];
            assign right_valid = valid[g+1];
        end

        stafm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_x           (i_x),
            .i_left_take   (left_take),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .o_take        (take[g]),
            .o_value       (value[g]),
            .o_valid       (valid[g])
        );
    end

    assign o_head_value        = value[0];
    assign o_stat.second_valid = valid[1];
    assign o_stat.full         = valid[CAPACITY-1];

endmodule

// ===== src/sort_tail_after_first_match.sv =====
// Top level of the suffix sorter: handshakes, target register and sequence control.
// Depends on stafm_pkg and stafm_chain.
//
// Usage: input words (i_value, i_last) arrive on i_valid/o_ready. Words before
// the first one equal to the target register are dropped; that word and all
// later ones are inserted into a row of CAPACITY cells, which keeps them in
// ascending order. Every cell compares in parallel and shifts by one, so
// o_ready stays high while a sequence is fed. The word with i_last set ends
// the sequence. The next cycle the results start on o_valid/i_ready, one per
// cycle while i_ready is high, smallest first, by shifting the row toward its
// head; run_end marks the last one. A stall holds the head of the row in place.
// With no match a single result with found low is given. During emission no
// input word is taken. Words beyond CAPACITY are dropped and overflow is set
// on every result of the run. The target register is written through
// i_cfg_we/i_cfg_data; the user must write it only while the block is idle,
// as the block has no check for it. Reset empties the row, clears the match
// and overflow flags and sets the target to zero.
module sort_tail_after_first_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  stafm_pkg::t_word  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  stafm_pkg::t_word  i_value,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output stafm_pkg::t_word  o_sorted_value,
    output logic              o_found,
    output logic              o_overflow,
    output logic              o_run_end
);
    import stafm_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_word       r_target;
    logic        r_match;
    logic        n_match;
    logic        r_drop;
    logic        n_drop;
    t_cell_ctl   ctl;
    t_chain_stat stat;
    t_word       head_value;
    logic        in_acc;
    logic        out_acc;
    logic        keep;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign keep    = r_match || (i_value == r_target);

    assign ctl.insert = in_acc && keep && !stat.full;
    assign ctl.unload = out_acc && (r_state == ST_EMIT);

    stafm_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_x          (i_value),
        .o_head_value (head_value),
        .o_stat       (stat)
    );

    always_comb begin
        n_state = r_state;
        n_match = r_match;
        n_drop  = r_drop;
        case (r_state)
            ST_COLLECT: begin
                if (in_acc) begin
                    n_match = keep;
                    if (keep && stat.full) begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_match = 1'b0;
                        n_state = keep ? ST_EMIT : ST_EMPTY;
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc && !stat.second_valid) begin
                    n_drop  = 1'b0;
                    n_state = ST_COLLECT;
                end
            end
            ST_EMPTY: begin
                if (out_acc) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_valid        = 1'b0;
        o_sorted_value = '0;
        o_found        = 1'b0;
        o_overflow     = 1'b0;
        o_run_end      = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_ready = 1'b1;
            end
            ST_EMIT: begin
                o_valid        = 1'b1;
                o_sorted_value = head_value;
                o_found        = 1'b1;
                o_overflow     = r_drop;
                o_run_end      = !stat.second_valid;
            end
            ST_EMPTY: begin
                o_valid   = 1'b1;
                o_run_end = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COLLECT;
            r_target <= '0;
            r_match  <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_match <= n_match;
            r_drop  <= n_drop;
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
        end
    end

endmodule

// ===== src/stafm_checker.sv =====
// Port-level checker for the suffix sorter, bound to the top level.
// Depends on assert_macros.svh and stafm_pkg.
`include "assert_macros.svh"

module stafm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input stafm_pkg::t_word  o_sorted_value,
    input logic              o_found,
    input logic              o_overflow,
    input logic              o_run_end
);

    // Results are never shown while a new word can be taken.
    `ASSERT_NEVER(a_no_overlap, o_ready && o_valid)

    // A miss is a single zero word that closes the run.
    `ASSERT_CLK(a_miss_word, o_valid && !o_found |-> o_run_end && !o_overflow && o_sorted_value == '0)

    // Within a run the words come out non-decreasing and stay found.
    `ASSERT_CLK(a_ordered, o_valid && i_ready && !o_run_end |=> o_valid && o_found && o_sorted_value >= $past(o_sorted_value))

    // After the closing word of a run the block takes input again.
    `ASSERT_CLK(a_back_to_input, o_valid && i_ready && o_run_end |=> o_ready)

endmodule

bind sort_tail_after_first_match stafm_checker u_stafm_checker (.*);
